// File: rtl/load_store_decode_agen_unit_assert.svh
// assertion macros for the checker file lsda_chk.sv
`ifndef LOAD_STORE_DECODE_AGEN_UNIT_ASSERT_SVH
`define LOAD_STORE_DECODE_AGEN_UNIT_ASSERT_SVH

// plain clocked assertion, quiet while reset is low
`define LSDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// assertion that only applies while a result strobe is out
`define LSDA_ASSERT_DONE(lbl, prop, msg) \
    `LSDA_ASSERT(lbl, o_done |-> (prop), msg)

`endif

// File: rtl/lsda_pkg.sv
`timescale 1ns / 1ps

package lsda_pkg;

    localparam int NUM_GROUPS = 25;
    localparam logic [4:0] GROUP_NONE = 5'd25;

    // result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_PRFM   = 3'd1;
    localparam logic [2:0] ST_FAIL   = 3'd2;
    localparam logic [2:0] ST_HANDOFF = 3'd3;
    localparam logic [2:0] ST_NOIMPL = 3'd4;

    localparam logic [4:0] REG_SP = 5'd31;

    typedef enum logic [1:0] {
        KIND_NOIMPL  = 2'd0,
        KIND_HANDOFF = 2'd1,
        KIND_IMM     = 2'd2,
        KIND_UNPRIV  = 2'd3
    } t_kind;

    localparam logic [31:0] GRP_MASK [NUM_GROUPS] = '{
        32'hB5A00000, 32'hB5BF0000, 32'hB5A00000, 32'hB59F0000, 32'hB5800000,
        32'hF5200000, 32'hB5A00000, 32'h35A00000, 32'h35A00000, 32'h35A00000,
        32'h35200C00, 32'h31000000, 32'h31200C00, 32'h31800000, 32'h31800000,
        32'h31800000, 32'h31800000, 32'h31200C00, 32'h31200C00, 32'h31200C00,
        32'h31200C00, 32'h31200C00, 32'h31200C00, 32'h31200400, 32'h31000000
    };

    localparam logic [31:0] GRP_CODE [NUM_GROUPS] = '{
        32'h00200000, 32'h04000000, 32'h04800000, 32'h05000000, 32'h05800000,
        32'hD1200000, 32'h80200000, 32'h00000000, 32'h00800000, 32'h00A00000,
        32'h11000000, 32'h10000000, 32'h10000400, 32'h20000000, 32'h20800000,
        32'h21000000, 32'h21800000, 32'h30000000, 32'h30000400, 32'h30000800,
        32'h30000C00, 32'h30200000, 32'h30200800, 32'h30200400, 32'h31000000
    };

    localparam t_kind GRP_KIND [NUM_GROUPS] = '{
        KIND_NOIMPL,  KIND_NOIMPL,  KIND_NOIMPL,  KIND_HANDOFF, KIND_HANDOFF,
        KIND_NOIMPL,  KIND_NOIMPL,  KIND_NOIMPL,  KIND_NOIMPL,  KIND_NOIMPL,
        KIND_NOIMPL,  KIND_NOIMPL,  KIND_NOIMPL,  KIND_HANDOFF, KIND_HANDOFF,
        KIND_HANDOFF, KIND_HANDOFF, KIND_IMM,     KIND_IMM,     KIND_UNPRIV,
        KIND_IMM,     KIND_NOIMPL,  KIND_HANDOFF, KIND_NOIMPL,  KIND_IMM
    };

    typedef struct packed {
        logic [31:0] instr_word;
        logic [63:0] base_value;
    } t_in;

    typedef struct packed {
        logic [4:0]  group;
        logic [2:0]  status;
        logic [63:0] access_address;
        logic [3:0]  access_bytes;
        logic        store_op;
        logic        sign_extend;
        logic        dest_is_32;
        logic [4:0]  data_reg;
        logic [4:0]  base_reg;
        logic        writeback_enable;
        logic [63:0] writeback_value;
    } t_out;

endpackage

// File: rtl/lsda_decode.sv
`timescale 1ns / 1ps

module lsda_decode (
    input  lsda_pkg::t_in  i_item,
    output lsda_pkg::t_out o_result
);

    logic [31:0]      w;
    logic [63:0]      base;
    logic [1:0]       size;
    logic [1:0]       opc;
    logic [4:0]       rn;
    logic [4:0]       rt;
    logic [4:0]       grp;
    lsda_pkg::t_kind  kind;
    logic             hit;
    logic [2:0]       status;
    logic             ok;
    logic             st;
    logic             sx;
    logic             d32;
    logic             wback;
    logic             post;
    logic             use_imm12;
    logic [63:0]      simm9;
    logic [63:0]      uimm;
    logic [63:0]      offset;
    logic [63:0]      sum;
    logic [3:0]       bytes;
    logic             en;

    assign w    = i_item.instr_word;
    assign base = i_item.base_value;
    assign size = w[31:30];
    assign opc  = w[23:22];
    assign rn   = w[9:5];
    assign rt   = w[4:0];

    // first match wins: scan from the top so the lowest index is kept
    always_comb begin
        grp  = lsda_pkg::GROUP_NONE;
        kind = lsda_pkg::KIND_NOIMPL;
        hit  = 1'b0;
        for (int i = lsda_pkg::NUM_GROUPS - 1; i >= 0; i--) begin
            if ((w & lsda_pkg::GRP_MASK[i]) == lsda_pkg::GRP_CODE[i]) begin
                grp  = 5'(i);
                kind = lsda_pkg::GRP_KIND[i];
                hit  = 1'b1;
            end
        end
    end

    always_comb begin
        status    = lsda_pkg::ST_FAIL;
        ok        = 1'b0;
        st        = 1'b0;
        sx        = 1'b0;
        d32       = 1'b0;
        wback     = 1'b0;
        post      = 1'b0;
        use_imm12 = 1'b0;
        if (hit) begin
            case (kind)
                lsda_pkg::KIND_NOIMPL: begin
                    status = lsda_pkg::ST_NOIMPL;
                end
                lsda_pkg::KIND_HANDOFF: begin
                    status = lsda_pkg::ST_HANDOFF;
                end
                lsda_pkg::KIND_UNPRIV: begin
                    ok = !w[26];
                    if (!opc[1]) begin
                        st  = !opc[0];
                        d32 = opc[0] && (size != 2'd3);
                    end else if (!opc[0]) begin
                        if (size == 2'd3) ok = 1'b0;
                        sx = 1'b1;
                    end else begin
                        if (size[1]) ok = 1'b0;
                        sx  = 1'b1;
                        d32 = 1'b1;
                    end
                    if (ok) status = lsda_pkg::ST_OK;
                end
                lsda_pkg::KIND_IMM: begin
                    if (w[26]) begin
                        status = lsda_pkg::ST_HANDOFF;
                    end else begin
                        use_imm12 = w[24];
                        wback     = !w[24] && w[10];
                        post      = !w[24] && w[10] && !w[11];
                        ok        = 1'b1;
                        if (!opc[1]) begin
                            st  = !opc[0];
                            d32 = opc[0] && (size != 2'd3);
                        end else if (size == 2'd3) begin
                            ok = 1'b0;
                            // prefetch only in unsigned offset and unscaled forms
                            if (!opc[0] && (w[24] || (w[11:10] == 2'b00)))
                                status = lsda_pkg::ST_PRFM;
                        end else begin
                            if (size == 2'd2 && opc[0]) ok = 1'b0;
                            sx  = 1'b1;
                            d32 = opc[0];
                        end
                        if (ok && wback && (rn == rt) && (rn != lsda_pkg::REG_SP))
                            ok = 1'b0;
                        if (ok) status = lsda_pkg::ST_OK;
                    end
                end
                default: begin
                    status = lsda_pkg::ST_FAIL;
                end
            endcase
        end
    end

    // single shared adder for every addressing form
    assign simm9  = {{55{w[20]}}, w[20:12]};
    assign uimm   = 64'({w[21:10], 3'b000}) >> (2'd3 - size);
    assign offset = use_imm12 ? uimm : simm9;
    assign sum    = base + offset;

    always_comb begin
        case (size)
            2'd0:    bytes = 4'd1;
            2'd1:    bytes = 4'd2;
            2'd2:    bytes = 4'd4;
            default: bytes = 4'd8;
        endcase
    end

    assign en = (status == lsda_pkg::ST_OK);

    always_comb begin
        o_result.group            = grp;
        o_result.status           = status;
        o_result.access_address   = en ? (post ? base : sum) : 64'd0;
        o_result.access_bytes     = en ? bytes : 4'd0;
        o_result.store_op         = en && st;
        o_result.sign_extend      = en && sx && !st;
        o_result.dest_is_32       = en && d32 && !st;
        o_result.data_reg         = en ? rt : 5'd0;
        o_result.base_reg         = en ? rn : 5'd0;
        o_result.writeback_enable = en && wback;
        o_result.writeback_value  = (en && wback) ? sum : 64'd0;
    end

endmodule

// File: rtl/load_store_decode_agen_unit.sv
`timescale 1ns / 1ps

// channel    direction  handshake                   payload
// command    in         i_start high, o_busy low    i_item   (lsda_pkg::t_in)
// result     out        o_done strobe, one cycle    o_result (lsda_pkg::t_out)
//
// one transaction per cycle; each result shows o_done once it has passed both registers
// latency is set by the input register and the result register around the decoder
// o_busy stays low: nothing in the decoder iterates or holds state between items
// synchronous active-low reset clears the two valid flags only
// the receiver cannot stall: o_done is high for a single cycle per result, o_result holds until the next

module load_store_decode_agen_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  lsda_pkg::t_in  i_item,
    output logic           o_done,
    output lsda_pkg::t_out o_result
);

    // input stage
    logic           r_in_vld;
    logic           n_in_vld;
    lsda_pkg::t_in  r_in;
    lsda_pkg::t_in  n_in;

    // result stage
    logic           r_out_vld;
    logic           n_out_vld;
    lsda_pkg::t_out r_out;
    lsda_pkg::t_out n_out;

    // decoder output for the item held in the input stage
    lsda_pkg::t_out dec_result;

    // decode is a single pass, so a new transaction can be taken every cycle
    assign o_busy = 1'b0;

    always_comb begin
        n_in_vld  = i_start && !o_busy;
        n_in      = n_in_vld ? i_item : r_in;
        n_out_vld = r_in_vld;
        n_out     = r_in_vld ? dec_result : r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

    // group match, status, size and one 64-bit address add
    lsda_decode u_decode (
        .i_item   (r_in),
        .o_result (dec_result)
    );

    assign o_done   = r_out_vld;
    assign o_result = r_out;

endmodule

// File: rtl/lsda_chk.sv
`timescale 1ns / 1ps

`include "load_store_decode_agen_unit_assert.svh"

module lsda_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_start,
    input logic           o_busy,
    input lsda_pkg::t_in  i_item,
    input logic           o_done,
    input lsda_pkg::t_out o_result
);

    logic decoded;
    logic payload_clear;
    logic shape_ok;

    assign decoded       = (o_result.status == lsda_pkg::ST_OK);
    assign payload_clear = (o_result.access_address == 64'd0) &&
                           (o_result.access_bytes == 4'd0) &&
                           !o_result.writeback_enable &&
                           (o_result.writeback_value == 64'd0);
    assign shape_ok      = $onehot(o_result.access_bytes) &&
                           !(o_result.store_op &&
                             (o_result.sign_extend || o_result.dest_is_32));

    // every transaction comes back through the input and result registers as o_done
    `LSDA_ASSERT(a_done_follows, (i_start && !o_busy) |-> ##2 o_done, "result missing")

    // no result without an earlier transaction that passed both registers
    `LSDA_ASSERT(a_done_caused, o_done |-> $past(i_start && !o_busy, 2), "spurious result")

    // anything but a decoded access carries zero address, size and writeback
    `LSDA_ASSERT_DONE(a_zero_fields, decoded || payload_clear, "payload not cleared")

    // decoded accesses have a power-of-two size and stores never extend
    `LSDA_ASSERT_DONE(a_access_shape, !decoded || shape_ok, "bad access shape")

endmodule

bind load_store_decode_agen_unit lsda_chk u_lsda_chk (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// checks the load/store decode and address generation unit
// a local decoder predicts every result, and the results are compared in order
// directed words come first, then random words that are mostly well-formed
// immediate and unprivileged forms; gaps come in random bursts, none at the end

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SHOWN_MISMATCHES = 10;

    // fields of the immediate and unprivileged encodings
    localparam logic [1:0] SZ_BYTE  = 2'd0;
    localparam logic [1:0] SZ_HALF  = 2'd1;
    localparam logic [1:0] SZ_WORD  = 2'd2;
    localparam logic [1:0] SZ_DWORD = 2'd3;

    localparam logic [1:0] OPC_STR    = 2'd0;
    localparam logic [1:0] OPC_LDR    = 2'd1;
    localparam logic [1:0] OPC_LDRS_X = 2'd2;
    localparam logic [1:0] OPC_LDRS_W = 2'd3;

    localparam logic [1:0] IX_UNSCALED = 2'd0;
    localparam logic [1:0] IX_POST     = 2'd1;
    localparam logic [1:0] IX_UNPRIV   = 2'd2;
    localparam logic [1:0] IX_PRE      = 2'd3;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    lsda_pkg::t_in    i_item;
    logic             o_done;
    lsda_pkg::t_out   o_result;

    lsda_pkg::t_out   decoded_q [$];
    lsda_pkg::t_out   want;
    int     error_cnt = 0;
    int     quiet_cycles = 0;

    load_store_decode_agen_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // builds a load/store word: size, V, unsigned-offset bit, opc, bits 21:10, Rn, Rt
    function automatic logic [31:0] ls_word(input logic [1:0] size, input logic simd,
                                            input logic [1:0] opc, input logic unsig,
                                            input logic [11:0] low12, input logic [4:0] rn,
                                            input logic [4:0] rt);
        return {size, 3'b111, simd, 1'b0, unsig, opc, low12, rn, rt};
    endfunction

    // expected decode of one instruction word against its base value
    function automatic lsda_pkg::t_out decode_expected(input lsda_pkg::t_in item);
        logic [31:0]    w;
        logic [63:0]    base;
        logic [4:0]     grp;
        logic [2:0]     status;
        logic [1:0]     size;
        logic [1:0]     opc;
        logic [4:0]     rn;
        logic [4:0]     rt;
        logic [63:0]    imm9;
        logic [63:0]    offset;
        logic           ok;
        logic           unsig;
        logic           wback;
        logic           post;
        lsda_pkg::t_out r;

        w      = item.instr_word;
        base   = item.base_value;
        grp    = lsda_pkg::GROUP_NONE;
        status = lsda_pkg::ST_FAIL;
        size   = w[31:30];
        opc    = w[23:22];
        rn     = w[9:5];
        rt     = w[4:0];
        imm9   = {{55{w[20]}}, w[20:12]};
        ok     = 1'b1;
        r      = '0;

        // walk the table backwards so the lowest matching entry is kept
        for (int i = lsda_pkg::NUM_GROUPS - 1; i >= 0; i--) begin
            if ((w & lsda_pkg::GRP_MASK[i]) == lsda_pkg::GRP_CODE[i])
                grp = i[4:0];
        end

        if (grp != lsda_pkg::GROUP_NONE) begin
            case (lsda_pkg::GRP_KIND[grp])
                lsda_pkg::KIND_NOIMPL:  status = lsda_pkg::ST_NOIMPL;
                lsda_pkg::KIND_HANDOFF: status = lsda_pkg::ST_HANDOFF;
                lsda_pkg::KIND_UNPRIV: begin
                    // unprivileged: no writeback, simd encodings are invalid
                    if (w[26]) begin
                        ok = 1'b0;
                    end else begin
                        case (opc)
                            OPC_STR: r.store_op = 1'b1;
                            OPC_LDR: r.dest_is_32 = (size != SZ_DWORD);
                            OPC_LDRS_X: begin
                                if (size == SZ_DWORD)
                                    ok = 1'b0;
                                r.sign_extend = 1'b1;
                            end
                            default: begin
                                if (size >= SZ_WORD)
                                    ok = 1'b0;
                                r.sign_extend = 1'b1;
                                r.dest_is_32  = 1'b1;
                            end
                        endcase
                    end
                    if (ok) begin
                        status           = lsda_pkg::ST_OK;
                        r.access_bytes   = 4'd1 << size;
                        r.access_address = base + imm9;
                    end
                end
                default: begin
                    if (w[26]) begin
                        // simd and fp immediate forms go elsewhere
                        status = lsda_pkg::ST_HANDOFF;
                    end else begin
                        unsig  = w[24];
                        wback  = !unsig && w[10];
                        post   = wback && !w[11];
                        offset = unsig ? ({52'b0, w[21:10]} << size) : imm9;
                        if (!opc[1]) begin
                            r.store_op   = !opc[0];
                            r.dest_is_32 = !r.store_op && (size != SZ_DWORD);
                        end else if (size == SZ_DWORD) begin
                            // prefetch only in the unsigned offset and unscaled forms
                            ok = 1'b0;
                            if (opc == OPC_LDRS_X && (unsig || w[11:10] == IX_UNSCALED))
                                status = lsda_pkg::ST_PRFM;
                        end else begin
                            if (size == SZ_WORD && opc == OPC_LDRS_W)
                                ok = 1'b0;
                            r.sign_extend = 1'b1;
                            r.dest_is_32  = opc[0];
                        end
                        // writeback onto the data register is invalid unless it is sp
                        if (ok && wback && rn == rt && rn != lsda_pkg::REG_SP)
                            ok = 1'b0;
                        if (ok) begin
                            status           = lsda_pkg::ST_OK;
                            r.access_bytes   = 4'd1 << size;
                            r.access_address = post ? base : base + offset;
                            if (wback) begin
                                r.writeback_enable = 1'b1;
                                r.writeback_value  = base + offset;
                            end
                        end
                    end
                end
            endcase
        end

        if (status != lsda_pkg::ST_OK) begin
            r = '0;
        end else begin
            r.data_reg = rt;
            r.base_reg = rn;
        end
        if (r.store_op) begin
            r.sign_extend = 1'b0;
            r.dest_is_32  = 1'b0;
        end
        r.group  = grp;
        r.status = status;
        return r;
    endfunction

    // one transaction: hold start until the unit takes it, then record the decode
    task automatic send_item(input logic [31:0] word, input logic [63:0] base);
        lsda_pkg::t_in item;
        item.instr_word = word;
        item.base_value = base;
        @(negedge i_clk);
        i_start <= 1'b1;
        i_item  <= item;
        do
            @(posedge i_clk);
        while (o_busy);
        decoded_q.push_back(decode_expected(item));
    endtask

    // start low with noise on the payload; n gives the length of the gap
    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            i_item  <= {$urandom, $urandom, $urandom};
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_drained();
        idle_cycles(1);
        while (decoded_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [63:0] random_base();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'hFFFF_FFFF_FFFF_FF00 | 64'($urandom_range(0, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // mostly well-formed immediate words, some aimed at any group, some pure noise
    function automatic logic [31:0] random_word();
        int         pick;
        int         g;
        logic [4:0] rn;
        logic [4:0] rt;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return $urandom;
        if (pick < 25) begin
            g = $urandom_range(0, lsda_pkg::NUM_GROUPS - 1);
            return ($urandom & ~lsda_pkg::GRP_MASK[g]) | lsda_pkg::GRP_CODE[g];
        end
        rn = 5'($urandom);
        if ($urandom_range(0, 7) == 0)
            rn = lsda_pkg::REG_SP;
        rt = ($urandom_range(0, 4) == 0) ? rn : 5'($urandom);
        if ($urandom_range(0, 2) == 0)
            return ls_word(2'($urandom), $urandom_range(0, 9) == 0, 2'($urandom), 1'b1,
                           12'($urandom), rn, rt);
        return ls_word(2'($urandom), $urandom_range(0, 9) == 0, 2'($urandom), 1'b0,
                       {1'b0, 9'($urandom), 2'($urandom)}, rn, rt);
    endfunction

    task automatic test_immediate_forms();
        // unsigned offset at the largest scaled immediate, address wraps
        send_item(ls_word(SZ_DWORD, 1'b0, OPC_LDR, 1'b1, 12'hFFF, 5'd3, 5'd4), '1);
        send_item(ls_word(SZ_BYTE, 1'b0, OPC_STR, 1'b1, 12'h000, lsda_pkg::REG_SP,
                          lsda_pkg::REG_SP), '0);
        // pre-index at the most negative offset
        send_item(ls_word(SZ_WORD, 1'b0, OPC_LDR, 1'b0, {1'b0, 9'h100, IX_PRE}, 5'd2, 5'd7),
                  64'h80);
        // post-index at the most positive offset, writeback onto sp as data too
        send_item(ls_word(SZ_DWORD, 1'b0, OPC_STR, 1'b0, {1'b0, 9'h0FF, IX_POST},
                          lsda_pkg::REG_SP, lsda_pkg::REG_SP), 64'h0123_4567_89AB_CDEF);
        send_item(ls_word(SZ_WORD, 1'b0, OPC_LDRS_X, 1'b0, {1'b0, 9'h1FF, IX_UNSCALED},
                          5'd9, 5'd10), 64'h1000);
        send_item(ls_word(SZ_HALF, 1'b0, OPC_LDRS_W, 1'b1, 12'h800, 5'd30, 5'd0),
                  64'hFFFF_0000_0000_0000);
        send_item(ls_word(SZ_BYTE, 1'b0, OPC_LDRS_X, 1'b0, {1'b0, 9'h001, IX_PRE},
                          5'd1, 5'd2), 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(ls_word(SZ_HALF, 1'b0, OPC_LDR, 1'b0, {1'b0, 9'h080, IX_POST},
                          5'd17, 5'd16), 64'h0000_0000_FFFF_FFFF);
    endtask

    task automatic test_special_cases();
        // prefetch in the unsigned offset and unscaled forms
        send_item(ls_word(SZ_DWORD, 1'b0, OPC_LDRS_X, 1'b1, 12'h123, 5'd5, 5'd1), 64'h4000);
        send_item(ls_word(SZ_DWORD, 1'b0, OPC_LDRS_X, 1'b0, {1'b0, 9'h1F0, IX_UNSCALED},
                          5'd5, 5'd1), 64'h4000);
        // prefetch encodings that index are undefined, and so are the word and dword LDRS_W forms
        send_item(ls_word(SZ_DWORD, 1'b0, OPC_LDRS_X, 1'b0, {1'b0, 9'h010, IX_PRE},
                          5'd6, 5'd8), 64'h4000);
        send_item(ls_word(SZ_DWORD, 1'b0, OPC_LDRS_X, 1'b0, {1'b0, 9'h010, IX_POST},
                          5'd6, 5'd8), 64'h4000);
        send_item(ls_word(SZ_DWORD, 1'b0, OPC_LDRS_W, 1'b1, 12'h001, 5'd6, 5'd8), 64'h4000);
        send_item(ls_word(SZ_WORD, 1'b0, OPC_LDRS_W, 1'b1, 12'h001, 5'd6, 5'd8), 64'h4000);
        // writeback with rn equal to rt
        send_item(ls_word(SZ_DWORD, 1'b0, OPC_LDR, 1'b0, {1'b0, 9'h008, IX_PRE},
                          5'd5, 5'd5), 64'h4000);
        // simd immediate form is handed off
        send_item(ls_word(SZ_DWORD, 1'b1, OPC_LDR, 1'b1, 12'h010, 5'd5, 5'd5), 64'h4000);
    endtask

    task automatic test_unprivileged();
        send_item(ls_word(SZ_BYTE, 1'b0, OPC_STR, 1'b0, {1'b0, 9'h1FF, IX_UNPRIV},
                          5'd11, 5'd11), 64'h0);
        send_item(ls_word(SZ_WORD, 1'b0, OPC_LDR, 1'b0, {1'b0, 9'h0FF, IX_UNPRIV},
                          lsda_pkg::REG_SP, 5'd12), '1);
        send_item(ls_word(SZ_WORD, 1'b0, OPC_LDRS_X, 1'b0, {1'b0, 9'h100, IX_UNPRIV},
                          5'd13, 5'd14), 64'h100);
        send_item(ls_word(SZ_HALF, 1'b0, OPC_LDRS_W, 1'b0, {1'b0, 9'h002, IX_UNPRIV},
                          5'd15, 5'd16), 64'h2000);
        send_item(ls_word(SZ_DWORD, 1'b0, OPC_LDRS_X, 1'b0, {1'b0, 9'h002, IX_UNPRIV},
                          5'd15, 5'd16), 64'h2000);
        send_item(ls_word(SZ_DWORD, 1'b1, OPC_LDR, 1'b0, {1'b0, 9'h002, IX_UNPRIV},
                          5'd15, 5'd16), 64'h2000);
    endtask

    task automatic test_group_table();
        send_item(32'h1120_0000, 64'h55);   // no entry matches
        send_item(32'h0000_0000, 64'h55);   // not implemented
        send_item(32'h0500_0000, 64'h55);   // handed off
    endtask

    // random words with bursts of idling whose density changes every 64 items
    task automatic test_random_mix(input int count);
        int gap_odds;
        gap_odds = 0;
        for (int k = 0; k < count; k++) begin
            if (k % 64 == 0)
                gap_odds = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 3 : 8);
            if (k > 0 && k % 400 == 0)
                wait_drained();
            send_item(random_word(), random_base());
            if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
                idle_cycles($urandom_range(1, 13));
        end
    endtask

    // start held high for every item
    task automatic test_back_to_back(input int count);
        for (int k = 0; k < count; k++)
            send_item(random_word(), random_base());
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
        error_cnt++;
        if (error_cnt <= SHOWN_MISMATCHES)
            $display("mismatch on %s: expected %h, got %h", what, exp_val, got);
    endtask

    // result checker, compares each strobed result with the oldest decode
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (decoded_q.size() == 0) begin
                error_cnt++;
                if (error_cnt <= SHOWN_MISMATCHES)
                    $display("unexpected result: %p", o_result);
            end else begin
                want = decoded_q.pop_front();
                if (o_result.group !== want.group)
                    note_mismatch("group", 64'(o_result.group), 64'(want.group));
                if (o_result.status !== want.status)
                    note_mismatch("status", 64'(o_result.status), 64'(want.status));
                if (o_result.access_address !== want.access_address)
                    note_mismatch("access_address", o_result.access_address,
                                  want.access_address);
                if (o_result.access_bytes !== want.access_bytes)
                    note_mismatch("access_bytes", 64'(o_result.access_bytes),
                                  64'(want.access_bytes));
                if (o_result.store_op !== want.store_op)
                    note_mismatch("store_op", 64'(o_result.store_op), 64'(want.store_op));
                if (o_result.sign_extend !== want.sign_extend)
                    note_mismatch("sign_extend", 64'(o_result.sign_extend),
                                  64'(want.sign_extend));
                if (o_result.dest_is_32 !== want.dest_is_32)
                    note_mismatch("dest_is_32", 64'(o_result.dest_is_32),
                                  64'(want.dest_is_32));
                if (o_result.data_reg !== want.data_reg)
                    note_mismatch("data_reg", 64'(o_result.data_reg), 64'(want.data_reg));
                if (o_result.base_reg !== want.base_reg)
                    note_mismatch("base_reg", 64'(o_result.base_reg), 64'(want.base_reg));
                if (o_result.writeback_enable !== want.writeback_enable)
                    note_mismatch("writeback_enable", 64'(o_result.writeback_enable),
                                  64'(want.writeback_enable));
                if (o_result.writeback_value !== want.writeback_value)
                    note_mismatch("writeback_value", o_result.writeback_value,
                                  want.writeback_value);
            end
        end
    end

    // watchdog: cycles with neither a transaction in nor a result out
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_immediate_forms();
        test_special_cases();
        test_unprivileged();
        test_group_table();
        wait_drained();
        test_random_mix(1375);
        wait_drained();
        test_back_to_back(250);
        wait_drained();

        // keep the clock running so any stray result is caught
        repeat (4) @(posedge i_clk);
        error_cnt += decoded_q.size();
        if (error_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/lsda_pkg.sv
rtl/lsda_decode.sv
rtl/load_store_decode_agen_unit.sv
rtl/lsda_chk.sv
tb/tb_top.sv
